FILE: hw/rtl/sem_pkg.sv
package sem_pkg;

    // Geometry limits
    localparam int SEM_MAX_WIDTH  = 1024;
    localparam int SEM_MAX_HEIGHT = 4096;
    localparam int SEM_MIN_DIM    = 3;

    // Field widths
    localparam int SEM_PIX_W      = 8;
    localparam int SEM_CFG_WID_W  = 11;
    localparam int SEM_CFG_HGT_W  = 13;
    localparam int SEM_CFG_DATA_W = 13;
    localparam int SEM_CFG_IDX_W  = 2;

    // Counter widths follow the limits
    localparam int SEM_COL_W  = $clog2(SEM_MAX_WIDTH);
    localparam int SEM_ROW_W  = $clog2(SEM_MAX_HEIGHT);
    localparam int SEM_WEFF_W = (SEM_COL_W + 1 > SEM_CFG_WID_W) ? SEM_COL_W + 1 : SEM_CFG_WID_W;
    localparam int SEM_HEFF_W = (SEM_ROW_W + 1 > SEM_CFG_HGT_W) ? SEM_ROW_W + 1 : SEM_CFG_HGT_W;

    // Register reset values
    localparam logic [SEM_CFG_WID_W-1:0] SEM_WIDTH_RST  = SEM_CFG_WID_W'(1024);
    localparam logic [SEM_CFG_HGT_W-1:0] SEM_HEIGHT_RST = SEM_CFG_HGT_W'(1024);

    // Gradient arithmetic
    localparam int SEM_SUM_W  = 10;                 // one kernel side, up to 1020
    localparam int SEM_GRAD_W = SEM_SUM_W + 1;      // signed gradient
    localparam logic [SEM_PIX_W-1:0] SEM_SAT_LIMIT = 8'hFF;

    // Result buffer
    localparam int SEM_FIFO_DEPTH = 8;
    localparam int SEM_FIFO_PTR_W = $clog2(SEM_FIFO_DEPTH);
    localparam int SEM_FIFO_CNT_W = $clog2(SEM_FIFO_DEPTH + 1);

    typedef enum logic [SEM_CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [SEM_COL_W-1:0] col;
        logic [SEM_PIX_W-1:0] pixel;
        logic                 produce;
        logic                 last;
    } t_stage1;

    typedef struct packed {
        logic [SEM_PIX_W-1:0] magnitude;
        logic                 frame_last;
    } t_result;

endpackage

FILE: hw/rtl/sem_pix_if.sv
interface sem_pix_if import sem_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SEM_PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: hw/rtl/sem_mag_if.sv
interface sem_mag_if import sem_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SEM_PIX_W-1:0] magnitude;
    logic                 frame_last;

    modport source (output valid, output magnitude, output frame_last, input ready);
    modport sink   (input valid, input magnitude, input frame_last, output ready);
endinterface

FILE: hw/rtl/sem_ram.sv
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/sobel_edge_magnitude.sv
// Streaming 3x3 Sobel edge detector, L1 magnitude saturated to 255.
// Pixels enter on i_pix in raster order, one item per clock when the block is
// ready. For every interior pixel (not in the first or last row or column) one
// item leaves on o_mag once its lower-right neighbor has arrived; frame_last
// marks the last interior result of a frame. Border values are up to the sink.
// Configuration: i_cfg_we writes image_width (index 0) or image_height
// (index 1) from i_cfg_data; any such write restarts the frame at row 0,
// column 0. Write only while the block is idle.
// Throughput: 1 pixel per cycle when the block is ready, set by the line store
// RAMs, which are read once and written once per pixel (read at accept, write
// back in the next cycle when the read data returns).
// Results drain through an 8-entry buffer; i_pix.ready drops only when that
// buffer plus the items still in the pipeline would overflow, so a stalled
// receiver back-pressures the source and nothing is lost.
// Reset (synchronous, active low) clears counters, window, pipeline and
// buffer and restores width and height to 1024. Line stores are not cleared:
// entries are written before any result uses them.
module sobel_edge_magnitude import sem_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [SEM_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SEM_CFG_DATA_W-1:0] i_cfg_data,
    sem_pix_if.sink                   i_pix,
    sem_mag_if.source                 o_mag
);

    // ---------------- configuration and position counters ----------------
    logic [SEM_CFG_WID_W-1:0] r_width;
    logic [SEM_CFG_HGT_W-1:0] r_height;
    logic [SEM_COL_W-1:0]     r_col;
    logic [SEM_ROW_W-1:0]     r_row;

    logic [SEM_WEFF_W-1:0] w_eff;
    logic [SEM_HEFF_W-1:0] h_eff;
    logic [SEM_COL_W-1:0]  cur_col;
    logic [SEM_ROW_W-1:0]  cur_row;
    logic [SEM_WEFF_W-1:0] col_inc;
    logic [SEM_HEFF_W-1:0] row_inc;
    logic [SEM_COL_W-1:0]  n_col;
    logic [SEM_ROW_W-1:0]  n_row;
    logic                  in_acc;
    logic                  cur_produce;
    logic                  cur_last;

    // Clamp the programmed geometry into the supported range
    always_comb begin
        if (SEM_WEFF_W'(r_width) < SEM_WEFF_W'(SEM_MIN_DIM)) begin
            w_eff = SEM_WEFF_W'(SEM_MIN_DIM);
        end else if (SEM_WEFF_W'(r_width) > SEM_WEFF_W'(SEM_MAX_WIDTH)) begin
            w_eff = SEM_WEFF_W'(SEM_MAX_WIDTH);
        end else begin
            w_eff = SEM_WEFF_W'(r_width);
        end
        if (SEM_HEFF_W'(r_height) < SEM_HEFF_W'(SEM_MIN_DIM)) begin
            h_eff = SEM_HEFF_W'(SEM_MIN_DIM);
        end else if (SEM_HEFF_W'(r_height) > SEM_HEFF_W'(SEM_MAX_HEIGHT)) begin
            h_eff = SEM_HEFF_W'(SEM_MAX_HEIGHT);
        end else begin
            h_eff = SEM_HEFF_W'(r_height);
        end
    end

    // Position of the incoming pixel, and where the next one lands
    always_comb begin
        cur_col = (SEM_WEFF_W'(r_col) >= w_eff) ? '0 : r_col;
        cur_row = (SEM_HEFF_W'(r_row) >= h_eff) ? '0 : r_row;

        cur_produce = (cur_row >= SEM_ROW_W'(2)) && (cur_col >= SEM_COL_W'(2));
        cur_last    = (SEM_HEFF_W'(cur_row) == h_eff - SEM_HEFF_W'(1))
                   && (SEM_WEFF_W'(cur_col) == w_eff - SEM_WEFF_W'(1));

        col_inc = SEM_WEFF_W'(cur_col) + SEM_WEFF_W'(1);
        row_inc = SEM_HEFF_W'(cur_row) + SEM_HEFF_W'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[SEM_ROW_W-1:0];
        end else begin
            n_col = col_inc[SEM_COL_W-1:0];
            n_row = cur_row;
        end
    end

    assign in_acc = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SEM_WIDTH_RST;
            r_height <= SEM_HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            // A write to a known register also restarts the frame
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[SEM_CFG_WID_W-1:0];
                    r_col   <= '0;
                    r_row   <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[SEM_CFG_HGT_W-1:0];
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1: line store read returns ----------------
    // The RAMs are read at the column of the accepted pixel; in the next cycle
    // the old rows come back, feed the window and are written back shifted
    // down by one row. The same column is not read again until the next row,
    // as the width is at least SEM_MIN_DIM, so no forwarding path is needed.
    t_stage1              r_s1;
    logic                 r_s1_vld;
    logic [SEM_PIX_W-1:0] up_rdata;
    logic [SEM_PIX_W-1:0] mid_rdata;

    sem_ram #(
        .WIDTH (SEM_PIX_W),
        .DEPTH (SEM_MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1.col),
        .i_wdata (mid_rdata),
        .i_raddr (cur_col),
        .o_rdata (up_rdata)
    );

    sem_ram #(
        .WIDTH (SEM_PIX_W),
        .DEPTH (SEM_MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1.col),
        .i_wdata (r_s1.pixel),
        .i_raddr (cur_col),
        .o_rdata (mid_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
        end
        if (in_acc) begin
            r_s1.col     <= cur_col;
            r_s1.pixel   <= i_pix.pixel;
            r_s1.produce <= cur_produce;
            r_s1.last    <= cur_last;
        end
    end

    // 3x3 window, row-major with the top row first; shift left one column
    logic [SEM_PIX_W-1:0] r_win [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_vld) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]   <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= up_rdata;
            r_win[5] <= mid_rdata;
            r_win[8] <= r_s1.pixel;
        end
    end

    // ---------------- stage 2: gradients ----------------
    // The window holds this item's neighborhood while r_s2_vld is high.
    logic                         r_s2_vld;
    logic                         r_s2_last;
    logic [SEM_SUM_W-1:0]         gx_pos;
    logic [SEM_SUM_W-1:0]         gx_neg;
    logic [SEM_SUM_W-1:0]         gy_pos;
    logic [SEM_SUM_W-1:0]         gy_neg;
    logic signed [SEM_GRAD_W-1:0] gx;
    logic signed [SEM_GRAD_W-1:0] gy;

    always_comb begin
        gx_pos = SEM_SUM_W'(r_win[2]) + SEM_SUM_W'({r_win[5], 1'b0})
               + SEM_SUM_W'(r_win[8]);
        gx_neg = SEM_SUM_W'(r_win[0]) + SEM_SUM_W'({r_win[3], 1'b0})
               + SEM_SUM_W'(r_win[6]);
        gy_pos = SEM_SUM_W'(r_win[6]) + SEM_SUM_W'({r_win[7], 1'b0})
               + SEM_SUM_W'(r_win[8]);
        gy_neg = SEM_SUM_W'(r_win[0]) + SEM_SUM_W'({r_win[1], 1'b0})
               + SEM_SUM_W'(r_win[2]);
        gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld && r_s1.produce;
        end
        r_s2_last <= r_s1.last;
    end

    // Register the gradients at the end of stage 2
    logic                         r_s3_vld;
    logic                         r_s3_last;
    logic signed [SEM_GRAD_W-1:0] r_gx;
    logic signed [SEM_GRAD_W-1:0] r_gy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_last <= r_s2_last;
        r_gx      <= gx;
        r_gy      <= gy;
    end

    // ---------------- stage 3: L1 magnitude and saturation ----------------
    logic [SEM_SUM_W-1:0] abs_gx;
    logic [SEM_SUM_W-1:0] abs_gy;
    logic [SEM_SUM_W:0]   mag_sum;
    t_result              s3_res;

    always_comb begin
        abs_gx  = r_gx[SEM_GRAD_W-1] ? SEM_SUM_W'(-r_gx) : SEM_SUM_W'(r_gx);
        abs_gy  = r_gy[SEM_GRAD_W-1] ? SEM_SUM_W'(-r_gy) : SEM_SUM_W'(r_gy);
        mag_sum = {1'b0, abs_gx} + {1'b0, abs_gy};
        s3_res.magnitude  = (mag_sum > (SEM_SUM_W+1)'(SEM_SAT_LIMIT))
                          ? SEM_SAT_LIMIT : mag_sum[SEM_PIX_W-1:0];
        s3_res.frame_last = r_s3_last;
    end

    // ---------------- result buffer ----------------
    // Hold results while the sink stalls; admit a pixel only when every
    // result already in flight is sure of a slot.
    t_result                   r_fifo [SEM_FIFO_DEPTH];
    logic [SEM_FIFO_PTR_W-1:0] r_wr_ptr;
    logic [SEM_FIFO_PTR_W-1:0] r_rd_ptr;
    logic [SEM_FIFO_CNT_W-1:0] r_cnt;
    logic                      push;
    logic                      pop;
    logic [SEM_FIFO_CNT_W:0]   committed;

    assign push = r_s3_vld;
    assign pop  = o_mag.valid && o_mag.ready;

    assign committed = (SEM_FIFO_CNT_W+1)'(r_cnt)
                     + (SEM_FIFO_CNT_W+1)'(r_s1_vld && r_s1.produce)
                     + (SEM_FIFO_CNT_W+1)'(r_s2_vld)
                     + (SEM_FIFO_CNT_W+1)'(r_s3_vld);

    assign i_pix.ready = committed < (SEM_FIFO_CNT_W+1)'(SEM_FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + SEM_FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + SEM_FIFO_PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + SEM_FIFO_CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - SEM_FIFO_CNT_W'(1);
            end
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= s3_res;
        end
    end

    assign o_mag.valid      = r_cnt != '0;
    assign o_mag.magnitude  = r_fifo[r_rd_ptr].magnitude;
    assign o_mag.frame_last = r_fifo[r_rd_ptr].frame_last;

endmodule

FILE: hw/rtl/sem_checker.sv
module sem_checker import sem_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [SEM_PIX_W-1:0] i_out_magnitude,
    input logic                 i_out_frame_last
);

    // Nothing comes out right after reset
    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_out_magnitude) && $stable(i_out_frame_last))
        else $error("stalled result changed");

    // One drained slot is enough to reopen the input
    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_ready) && $past(i_rst_n) |-> i_in_ready)
        else $error("input held off although the sink was taking items");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_pix.ready),
    .i_out_valid      (o_mag.valid),
    .i_out_ready      (o_mag.ready),
    .i_out_magnitude  (o_mag.magnitude),
    .i_out_frame_last (o_mag.frame_last)
);
